/* sv/countdown_timer_table_assert.svh */
// Assertion macros for the countdown timer table, clocked on clk with rst_n low as reset.
`ifndef COUNTDOWN_TIMER_TABLE_ASSERT_SVH
`define COUNTDOWN_TIMER_TABLE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define CTT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ctt_pkg.sv */
`default_nettype none
package ctt_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int TIME_BITS_DEF  = 24;
  localparam logic [31:0] HANDLE_BASE = 32'h0000_1234;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    REQ_CREATE    = 3'd0,
    REQ_DESTROY   = 3'd1,
    REQ_START     = 3'd2,
    REQ_STOP      = 3'd3,
    REQ_RESET     = 3'd4,
    REQ_SET_DELAY = 3'd5,
    REQ_TICK      = 3'd6,
    REQ_QUERY     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_EXPIRED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WB,
    ST_SCAN,
    ST_ALLOC,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic stopped;
    logic running;
    logic expired;
  } status_t;

  typedef struct packed {
    logic        is_expired;
    logic        is_running;
    logic        is_stopped;
    logic        accepted;
    logic [31:0] new_handle;
  } result_t;

endpackage
`default_nettype wire

/* sv/ctt_entry_upd.sv */
`default_nettype none
module ctt_entry_upd
  import ctt_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  req_t                 op,
  input  logic [TIME_BITS-1:0] amount,
  input  logic                 live_i,
  input  mode_t                mode_i,
  input  logic [TIME_BITS-1:0] delay_i,
  input  logic [TIME_BITS+1:0] cd_i,
  output logic                 live_o,
  output mode_t                mode_o,
  output logic [TIME_BITS-1:0] delay_o,
  output logic [TIME_BITS+1:0] cd_o,
  output status_t              status
);

  logic [TIME_BITS+1:0] diff;

  assign diff = cd_i - {2'b00, amount};

  always_comb begin
    live_o  = live_i;
    mode_o  = mode_i;
    delay_o = delay_i;
    cd_o    = cd_i;
    status  = '0;
    unique case (op)
      REQ_CREATE: begin
        live_o  = 1'b1;
        mode_o  = MODE_STOPPED;
        delay_o = '0;
        cd_o    = '0;
      end
      REQ_DESTROY: begin
        live_o = 1'b0;
        mode_o = MODE_STOPPED;
        cd_o   = '0;
      end
      REQ_START: begin
        if ((delay_i != '0) && (mode_i == MODE_STOPPED)) begin
          mode_o = MODE_RUNNING;
          cd_o   = {2'b00, delay_i};
        end
      end
      REQ_STOP, REQ_RESET: begin
        mode_o = MODE_STOPPED;
        cd_o   = '0;
      end
      REQ_SET_DELAY: begin
        delay_o = amount;
      end
      REQ_TICK: begin
        if (live_i && (mode_i == MODE_RUNNING)) begin
          cd_o = diff;
          if (diff[TIME_BITS+1]) begin
            mode_o = MODE_EXPIRED;
          end
        end
      end
      REQ_QUERY: begin
        status.stopped = (mode_i == MODE_STOPPED);
        status.running = (mode_i == MODE_RUNNING);
        status.expired = (mode_i == MODE_EXPIRED);
      end
      default: begin
        live_o = live_i;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/countdown_timer_table.sv */
`default_nettype none
// Bank of NUM_TIMERS one-shot countdown timers held in one single-port-write,
// registered-read slot memory. Requests arrive on the in_ stream (opcode in
// in_tuser), one result per request leaves on the out_ stream. Requests are
// handled one at a time: create and tick sweep every allocated slot through
// the memory, one slot per cycle. All other requests do one read-modify-write
// of the addressed slot.
// The input is taken again while the previous result still waits on out_.
// Handles are slot index plus 0x1234; times are in 1/256 ms units.
module countdown_timer_table
  import ctt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // handle[31:0], amount[55:32]
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // req_type[2:0]
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata   // new_handle[31:0], accepted[32],
                                                 // is_stopped[33], is_running[34],
                                                 // is_expired[35], zero[39:36]
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int MEM_W = 3 + TIME_BITS + TIME_BITS + 2;

  state_t               state_r, state_nxt;
  req_t                 req_r, req_nxt;
  logic [TIME_BITS-1:0] amount_r, amount_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 pv_r, pv_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  result_t              res_r, res_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [MEM_W-1:0]     mem_r [NUM_TIMERS];
  logic [MEM_W-1:0]     rdata_r;
  logic [IDX_W-1:0]     raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [MEM_W-1:0]     mem_wdata;

  logic                      in_fire;
  req_t                      in_req;
  logic [31:0]               in_handle;
  logic [23:0]               in_amount;
  logic [TIME_BITS+23:0]     amount_ext;
  logic [31:0]               idx_full;
  logic                      scan_issue;

  logic                 rd_live;
  mode_t                rd_mode;
  logic [TIME_BITS-1:0] rd_delay;
  logic [TIME_BITS+1:0] rd_cd;
  logic                 up_live;
  mode_t                up_mode;
  logic [TIME_BITS-1:0] up_delay;
  logic [TIME_BITS+1:0] up_cd;
  status_t              up_status;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_req     = req_t'(in_tuser[2:0]);
  assign in_handle  = in_tdata[31:0];
  assign in_amount  = in_tdata[55:32];
  assign amount_ext = {{TIME_BITS{1'b0}}, in_amount};
  assign idx_full   = in_handle - HANDLE_BASE;
  assign scan_issue = (scan_r < used_r);

  assign {rd_live, rd_mode, rd_delay, rd_cd} =
    {rdata_r[MEM_W-1], mode_t'(rdata_r[MEM_W-2:MEM_W-3]), rdata_r[MEM_W-4:0]};

  ctt_entry_upd #(
    .TIME_BITS (TIME_BITS)
  ) u_upd (
    .op      (req_r),
    .amount  (amount_r),
    .live_i  (rd_live),
    .mode_i  (rd_mode),
    .delay_i (rd_delay),
    .cd_i    (rd_cd),
    .live_o  (up_live),
    .mode_o  (up_mode),
    .delay_o (up_delay),
    .cd_o    (up_cd),
    .status  (up_status)
  );

  assign mem_wdata = {up_live, up_mode, up_delay, up_cd};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    amount_nxt    = amount_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    pv_nxt        = pv_r;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    raddr         = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt    = in_req;
          amount_nxt = amount_ext[TIME_BITS-1:0];
          hit_nxt    = (idx_full < {{(32-CNT_W){1'b0}}, used_r});
          idx_nxt    = idx_full[IDX_W-1:0];
          scan_nxt   = '0;
          pv_nxt     = 1'b0;
          found_nxt  = 1'b0;
          res_nxt    = '0;
          if ((in_req == REQ_CREATE) || (in_req == REQ_TICK)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        raddr     = idx_r;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (hit_r && rd_live) begin
          res_nxt.accepted = 1'b1;
          if (req_r == REQ_QUERY) begin
            res_nxt.is_stopped = up_status.stopped;
            res_nxt.is_running = up_status.running;
            res_nxt.is_expired = up_status.expired;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
          end
        end
        state_nxt = ST_PUSH;
      end
      ST_SCAN: begin
        raddr  = scan_r[IDX_W-1:0];
        pv_nxt = scan_issue;
        if (scan_issue) begin
          scan_nxt = scan_r + 1'b1;
          pidx_nxt = scan_r[IDX_W-1:0];
        end
        if (pv_r) begin
          if (req_r == REQ_TICK) begin
            mem_we    = 1'b1;
            mem_waddr = pidx_r;
          end else if (!rd_live) begin
            found_nxt = 1'b1;
            pick_nxt  = pidx_r;
          end
        end
        if (!scan_issue && !pv_r) begin
          if (req_r == REQ_TICK) begin
            res_nxt.accepted = 1'b1;
            state_nxt        = ST_PUSH;
          end else begin
            state_nxt = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        if (found_r) begin
          mem_we             = 1'b1;
          mem_waddr          = pick_r;
          res_nxt.accepted   = 1'b1;
          res_nxt.new_handle = HANDLE_BASE + {{(32-IDX_W){1'b0}}, pick_r};
        end else if (used_r < CNT_W'(NUM_TIMERS)) begin
          mem_we             = 1'b1;
          mem_waddr          = used_r[IDX_W-1:0];
          used_nxt           = used_r + 1'b1;
          res_nxt.accepted   = 1'b1;
          res_nxt.new_handle = HANDLE_BASE + {{(32-CNT_W){1'b0}}, used_r};
        end
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    amount_r <= amount_nxt;
    hit_r    <= hit_nxt;
    idx_r    <= idx_nxt;
    scan_r   <= scan_nxt;
    pidx_r   <= pidx_nxt;
    found_r  <= found_nxt;
    pick_r   <= pick_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.is_expired, out_r.is_running, out_r.is_stopped,
                       out_r.accepted, out_r.new_handle};

`include "countdown_timer_table_assert.svh"

  `CTT_ASSERT_ALWAYS(a_used_bound, used_r <= CNT_W'(NUM_TIMERS), "slot count past table size")
  `CTT_ASSERT_IMP(a_scan_no_clash,
                  mem_we && (state_r == ST_SCAN) && scan_issue,
                  mem_waddr != raddr, "sweep writes the slot it reads")
  `CTT_ASSERT_NEXT(a_busy_after_take, in_fire, state_r != ST_IDLE, "idle right after taking")
  `CTT_ASSERT_NEXT(a_push_lands,
                   (state_r == ST_PUSH) && !out_valid_r,
                   out_valid_r && (state_r == ST_IDLE), "result not moved to output")

endmodule
`default_nettype wire

/* bench/tb_countdown_timer_table.sv */
module tb_countdown_timer_table;
  import ctt_pkg::*;

  localparam int NT           = NUM_TIMERS_DEF;
  localparam int TB_TIME_W    = TIME_BITS_DEF;
  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 3 * (NT + 4);

  typedef struct {
    req_t    req;
    result_t res;
  } owed_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;  // handle[31:0], amount[55:32]
  logic [IN_USER_W-1:0]  in_tuser  = '0;  // req_type[2:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // new_handle[31:0], accepted[32], is_stopped[33],
                                          // is_running[34], is_expired[35], zero[39:36]

  // shadow timer table
  logic                       tm_live  [NT];
  mode_t                      tm_mode  [NT];
  logic [TB_TIME_W-1:0]       tm_delay [NT];
  logic signed [TB_TIME_W+1:0] tm_left [NT];
  int unsigned                tm_used;

  owed_t   owed_replies[$];
  owed_t   chk_want;
  result_t chk_got;
  int      fails      = 0;
  int      reply_cnt  = 0;
  int      cycles     = 0;
  int      burst_left = 0;
  bit      gaps_on    = 1'b1;

  int         rx_mode   = 0;
  logic [7:0] rx_mask   = 8'h5b;
  int         hold_left = 0;
  int         hold_asks = 0;
  int         hold_seen = 0;

  countdown_timer_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall modes, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen  <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= rx_mask[0];
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
    if ($urandom_range(0, 63) == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mask <= 8'($urandom) | 8'h01;
    end else begin
      rx_mask <= {rx_mask[6:0], rx_mask[7]};
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      reply_cnt++;
      chk_got = out_tdata[35:0];
      if (owed_replies.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("reply %0d: no request outstanding, got %h", reply_cnt, out_tdata);
      end else begin
        chk_want = owed_replies.pop_front();
        if (chk_got.new_handle !== chk_want.res.new_handle ||
            chk_got.accepted   !== chk_want.res.accepted   ||
            chk_got.is_stopped !== chk_want.res.is_stopped ||
            chk_got.is_running !== chk_want.res.is_running ||
            chk_got.is_expired !== chk_want.res.is_expired ||
            out_tdata[39:36]   !== 4'h0) begin
          fails++;
          if (fails <= 10)
            $display("reply %0d (%s): want %h/%b/%b%b%b, got %h/%b/%b%b%b pad %h",
                     reply_cnt, chk_want.req.name(), chk_want.res.new_handle,
                     chk_want.res.accepted, chk_want.res.is_stopped,
                     chk_want.res.is_running, chk_want.res.is_expired,
                     chk_got.new_handle, chk_got.accepted, chk_got.is_stopped,
                     chk_got.is_running, chk_got.is_expired, out_tdata[39:36]);
        end
      end
    end
  end

  task automatic predict_reply(input req_t r, input logic [31:0] h,
                               input logic [TB_TIME_W-1:0] a, output result_t res);
    int          pick;
    logic [31:0] idx;
    res = '0;
    case (r)
      REQ_CREATE: begin
        pick = -1;
        for (int i = 0; i < tm_used; i++)
          if (!tm_live[i]) pick = i;
        if (pick < 0 && tm_used < NT) begin
          pick = tm_used;
          tm_used++;
        end
        if (pick >= 0) begin
          tm_live[pick]  = 1'b1;
          tm_delay[pick] = '0;
          tm_mode[pick]  = MODE_STOPPED;
          tm_left[pick]  = '0;
          res.new_handle = HANDLE_BASE + pick;
          res.accepted   = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < tm_used; i++) begin
          if (tm_live[i] && tm_mode[i] == MODE_RUNNING) begin
            tm_left[i] = tm_left[i] - $signed({2'b00, a});
            if (tm_left[i] < 0) tm_mode[i] = MODE_EXPIRED;
          end
        end
        res.accepted = 1'b1;
      end
      default: begin
        idx = h - HANDLE_BASE;
        if (idx < tm_used && tm_live[idx[4:0]]) begin
          res.accepted = 1'b1;
          case (r)
            REQ_DESTROY: begin
              tm_live[idx[4:0]] = 1'b0;
              tm_mode[idx[4:0]] = MODE_STOPPED;
              tm_left[idx[4:0]] = '0;
            end
            REQ_START: begin
              if (tm_delay[idx[4:0]] != 0 && tm_mode[idx[4:0]] == MODE_STOPPED) begin
                tm_mode[idx[4:0]] = MODE_RUNNING;
                tm_left[idx[4:0]] = $signed({2'b00, tm_delay[idx[4:0]]});
              end
            end
            REQ_STOP, REQ_RESET: begin
              tm_mode[idx[4:0]] = MODE_STOPPED;
              tm_left[idx[4:0]] = '0;
            end
            REQ_SET_DELAY: tm_delay[idx[4:0]] = a;
            REQ_QUERY: begin
              res.is_stopped = (tm_mode[idx[4:0]] == MODE_STOPPED);
              res.is_running = (tm_mode[idx[4:0]] == MODE_RUNNING);
              res.is_expired = (tm_mode[idx[4:0]] == MODE_EXPIRED);
            end
            default: ;
          endcase
        end
      end
    endcase
  endtask

  task automatic send_req(input req_t r, input logic [31:0] h,
                          input logic [TB_TIME_W-1:0] a, output result_t res);
    int    gap;
    owed_t o;
    if (burst_left <= 0) begin
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r;
    in_tdata  <= {a, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    predict_reply(r, h, a, res);
    o.req = r;
    o.res = res;
    owed_replies.insert(owed_replies.size(), o);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TB_TIME_W-1:0] rand_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return TB_TIME_W'($urandom);
      default: return TB_TIME_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [31:0] stray_handle();
    int freed[$];
    for (int i = 0; i < tm_used; i++)
      if (!tm_live[i]) freed.insert(freed.size(), i);
    case ($urandom_range(0, 5))
      0: if (freed.size() != 0) return HANDLE_BASE + freed[$urandom_range(0, freed.size() - 1)];
      1: if (tm_used < NT) return HANDLE_BASE + $urandom_range(tm_used, NT - 1);
      2: return HANDLE_BASE + $urandom_range(NT, 4096);
      3: return $urandom_range(0, HANDLE_BASE - 1);
      4: return 32'hFFFF_FFFF;
      default: ;
    endcase
    return $urandom;
  endfunction

  function automatic logic [31:0] live_handle();
    int pool[$];
    for (int i = 0; i < tm_used; i++)
      if (tm_live[i]) pool.insert(pool.size(), i);
    if (pool.size() == 0) return stray_handle();
    return HANDLE_BASE + pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // weights in opcode order: create, destroy, start, stop, reset, set delay, tick, query
  task automatic rand_request(input int w[8]);
    int          total;
    int          pick;
    req_t        r;
    logic [31:0] h;
    result_t     res;
    total = 0;
    foreach (w[i]) total += w[i];
    pick = $urandom_range(0, total - 1);
    r = REQ_CREATE;
    for (int i = 0; i < 8; i++) begin
      if (pick >= 0 && pick < w[i]) r = req_t'(i);
      pick -= w[i];
    end
    h = ($urandom_range(0, 99) < 85) ? live_handle() : stray_handle();
    if (r == REQ_CREATE || r == REQ_TICK) h = $urandom;
    send_req(r, h, rand_amount(), res);
  endtask

  // program, start, tick toward expiry (with some queries), then stop, reset, destroy or query one timer
  task automatic run_timer_life();
    result_t              res;
    logic [31:0]          h;
    logic [TB_TIME_W-1:0] d;
    res = '0;
    if ($urandom_range(0, 3) == 0) send_req(REQ_CREATE, $urandom, rand_amount(), res);
    h = res.accepted ? res.new_handle : live_handle();
    d = ($urandom_range(0, 9) == 0) ? rand_amount() : TB_TIME_W'($urandom_range(1, 4000));
    send_req(REQ_SET_DELAY, h, d, res);
    send_req(REQ_START, h, rand_amount(), res);
    repeat ($urandom_range(1, 5)) begin
      send_req(REQ_TICK, $urandom, TB_TIME_W'($urandom_range(0, d)), res);
      if ($urandom_range(0, 2) == 0) send_req(REQ_QUERY, h, TB_TIME_W'($urandom), res);
    end
    case ($urandom_range(0, 3))
      0:       send_req(REQ_STOP, h, TB_TIME_W'($urandom), res);
      1:       send_req(REQ_RESET, h, TB_TIME_W'($urandom), res);
      2:       send_req(REQ_DESTROY, h, TB_TIME_W'($urandom), res);
      default: send_req(REQ_QUERY, h, TB_TIME_W'($urandom), res);
    endcase
  endtask

  task automatic test_directed();
    result_t     res;
    logic [31:0] h0;
    logic [31:0] h1;
    gaps_on = 1'b0;
    send_req(REQ_QUERY, HANDLE_BASE, '0, res);
    send_req(REQ_CREATE, '0, '0, res);
    h0 = res.new_handle;
    send_req(REQ_QUERY, h0, '1, res);
    send_req(REQ_START, h0, '0, res);
    send_req(REQ_QUERY, h0, '0, res);
    send_req(REQ_SET_DELAY, h0, '1, res);
    send_req(REQ_START, h0, '0, res);
    send_req(REQ_START, h0, '0, res);
    send_req(REQ_TICK, '1, '0, res);
    send_req(REQ_TICK, '0, '1, res);
    send_req(REQ_QUERY, h0, '0, res);
    send_req(REQ_TICK, 32'hA5A5_5A5A, 24'd1, res);
    send_req(REQ_QUERY, h0, '0, res);
    send_req(REQ_START, h0, '0, res);
    send_req(REQ_TICK, HANDLE_BASE, '1, res);
    send_req(REQ_RESET, h0, '0, res);
    send_req(REQ_SET_DELAY, h0, 24'd1, res);
    send_req(REQ_START, h0, '0, res);
    send_req(REQ_STOP, h0, '0, res);
    send_req(REQ_CREATE, '1, '1, res);
    h1 = res.new_handle;
    send_req(REQ_DESTROY, h0, '0, res);
    send_req(REQ_QUERY, h0, '0, res);
    send_req(REQ_START, h0, '0, res);
    send_req(REQ_SET_DELAY, HANDLE_BASE + 5, '1, res);
    send_req(REQ_QUERY, 32'hFFFF_FFFF, '0, res);
    send_req(REQ_DESTROY, '0, '0, res);
    send_req(REQ_CREATE, '0, '0, res);
    send_req(REQ_QUERY, h1, '0, res);
  endtask

  task automatic test_fill_table();
    gaps_on = 1'b1;
    repeat (150) rand_request('{40, 4, 8, 4, 4, 10, 10, 20});
  endtask

  task automatic test_random_mix();
    repeat (9) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (20) begin
        if ($urandom_range(0, 9) < 4) run_timer_life();
        else rand_request('{8, 6, 18, 6, 6, 16, 20, 20});
      end
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (60) rand_request('{8, 4, 18, 6, 6, 16, 20, 22});
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    repeat (6) begin
      repeat (10) rand_request('{8, 6, 18, 6, 6, 16, 20, 20});
      wait_drained();
    end
  endtask

  task automatic test_churn();
    gaps_on = 1'b1;
    repeat (75) rand_request('{6, 30, 8, 6, 6, 10, 14, 20});
    repeat (75) rand_request('{35, 5, 10, 5, 5, 10, 10, 20});
  endtask

  initial begin
    for (int i = 0; i < NT; i++) begin
      tm_live[i]  = 1'b0;
      tm_mode[i]  = MODE_STOPPED;
      tm_delay[i] = '0;
      tm_left[i]  = '0;
    end
    tm_used = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_fill_table();
    wait_drained();
    test_random_mix();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_drain_pause();
    test_churn();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && owed_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
